/* rtl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Receive phases
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_ID,
        PH_SEQ,
        PH_LENLO,
        PH_LENHI,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    // End-of-frame status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_BAD_SUM  = 3'd3,
        ST_OTHER    = 3'd4
    } status_t;

    localparam logic [7:0] ESC_BYTE  = 8'hFF;
    localparam logic [7:0] TYPE_DATA = 8'h02;
    localparam logic [7:0] ESC_NULL  = 8'h00;

    localparam logic [15:0] MAX_LENGTH_RST = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

    // Configuration register map (index taken from paddr[2])
    localparam int         ADDR_W         = 3;
    localparam logic [0:0] REG_MAX_LENGTH = 1'b0;
    localparam logic [0:0] REG_TIMEOUT    = 1'b1;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_IDX_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // One result beat; last is the same bit as kind
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        status_t     status;
        logic [7:0]  frame_id;
        logic [7:0]  frame_seq;
        logic [15:0] frame_length;
    } result_t;

    // Deframer state
    typedef struct packed {
        phase_t      phase;
        logic        pend;
        logic [7:0]  sum;
        logic [7:0]  id;
        logic [7:0]  seq;
        logic [15:0] len;
        logic [15:0] seen;
        logic [15:0] idle;
    } fstate_t;

    // Up to two results pushed into the output queue in one cycle
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

/* rtl/sfr_cfg.sv */
// ----------------------------------------------------------------------------
// sfr_cfg
// APB register block holding the maximum length and the timeout.
// ----------------------------------------------------------------------------
module sfr_cfg
    import sfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [15:0]       max_length,
    output logic [15:0]       timeout_ticks
);

    logic [15:0] max_length_reg;
    logic [15:0] timeout_reg;
    logic [0:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
            timeout_reg    <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MAX_LENGTH: max_length_reg <= pwdata[15:0];
                REG_TIMEOUT:    timeout_reg    <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MAX_LENGTH: prdata = {16'd0, max_length_reg};
            REG_TIMEOUT:    prdata = {16'd0, timeout_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign max_length    = max_length_reg;
    assign timeout_ticks = timeout_reg;

endmodule

/* rtl/sfr_core.sv */
// ----------------------------------------------------------------------------
// sfr_core
// Input register, deframer state and the single-pass next-state logic.
// ----------------------------------------------------------------------------
module sfr_core
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_op,
    input  logic [7:0]  in_byte,
    input  logic [15:0] max_length,
    input  logic [15:0] timeout_ticks,
    input  logic        room,
    output push_t       push
);

    typedef struct packed {
        fstate_t st;
        logic    rv;
        result_t res;
    } field_t;

    logic        in_vld_reg;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;
    fstate_t     st_reg;
    fstate_t     st_next;
    field_t      f1;
    field_t      f2;
    logic        adv;
    logic [15:0] tmo;
    logic [15:0] idle_inc;

    function automatic result_t make_res(fstate_t s, logic kind, logic [7:0] d,
                                         status_t stat);
        result_t r;
        r.kind         = kind;
        r.data         = d;
        r.status       = stat;
        r.frame_id     = s.id;
        r.frame_seq    = s.seq;
        r.frame_length = s.len;
        return r;
    endfunction

    function automatic fstate_t end_frame(fstate_t s);
        fstate_t t;
        t       = s;
        t.phase = PH_HUNT;
        t.pend  = 1'b0;
        t.idle  = 16'd0;
        return t;
    endfunction

    // One unstuffed field byte
    function automatic field_t take_field(fstate_t s, logic [7:0] v, logic [15:0] mlen);
        field_t      f;
        logic [15:0] nlen;
        logic [15:0] nseen;
        f.st     = s;
        f.rv     = 1'b0;
        f.res    = make_res(s, 1'b0, 8'd0, ST_OK);
        f.st.sum = s.sum + v;
        nlen     = {v, s.len[7:0]};
        nseen    = s.seen + 16'd1;
        case (s.phase)
            PH_ID:
            begin
                f.st.id    = v;
                f.st.phase = PH_SEQ;
            end
            PH_SEQ:
            begin
                f.st.seq   = v;
                f.st.phase = PH_LENLO;
            end
            PH_LENLO:
            begin
                f.st.len   = {8'd0, v};
                f.st.phase = PH_LENHI;
            end
            PH_LENHI:
            begin
                f.st.len  = nlen;
                f.st.seen = 16'd0;
                if (nlen > mlen)
                begin
                    f.rv  = 1'b1;
                    f.res = make_res(f.st, 1'b1, 8'd0, ST_TOO_LONG);
                    f.st  = end_frame(f.st);
                end
                else if (nlen == 16'd0)
                    f.st.phase = PH_CHECK;
                else
                    f.st.phase = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                f.rv      = 1'b1;
                f.res     = make_res(s, 1'b0, v, ST_OK);
                f.st.seen = nseen;
                if (nseen >= s.len)
                    f.st.phase = PH_CHECK;
            end
            PH_CHECK:
            begin
                f.rv  = 1'b1;
                f.res = make_res(f.st, 1'b1, 8'd0,
                                 (f.st.sum == 8'd0) ? ST_OK : ST_BAD_SUM);
                f.st  = end_frame(f.st);
            end
            default: ;
        endcase
        return f;
    endfunction

    assign adv      = in_vld_reg && room;
    assign in_ready = !in_vld_reg || room;
    assign tmo      = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
    assign idle_inc = (st_reg.idle != 16'hFFFF) ? st_reg.idle + 16'd1 : st_reg.idle;

    always_comb
    begin
        st_next = st_reg;
        push    = '0;
        f1      = take_field(st_reg, in_byte_reg, max_length);
        f2      = take_field(f1.st, in_byte_reg, max_length);
        if (in_op_reg)
        begin
            if (st_reg.phase != PH_HUNT)
            begin
                st_next.idle = idle_inc;
                if (idle_inc >= tmo)
                begin
                    push.v0 = 1'b1;
                    push.r0 = make_res(st_next, 1'b1, 8'd0, ST_TIMEOUT);
                    st_next = end_frame(st_next);
                end
            end
        end
        else
        begin
            st_next.idle = 16'd0;
            if (st_reg.phase == PH_HUNT)
            begin
                if (in_byte_reg == ESC_BYTE)
                begin
                    st_next.phase = PH_TYPE;
                    st_next.pend  = 1'b0;
                    st_next.sum   = 8'd0;
                    st_next.id    = 8'd0;
                    st_next.seq   = 8'd0;
                    st_next.len   = 16'd0;
                    st_next.seen  = 16'd0;
                end
            end
            else if (st_reg.phase == PH_TYPE)
            begin
                if (in_byte_reg == TYPE_DATA)
                    st_next.phase = PH_ID;
                else
                begin
                    push.v0 = 1'b1;
                    push.r0 = make_res(st_reg, 1'b1, in_byte_reg, ST_OTHER);
                    st_next = end_frame(st_next);
                end
            end
            else if (st_reg.pend)
            begin
                // Escape pending: the held 0xFF is a field byte, and a byte
                // other than the null code follows it as a field byte as well.
                f1      = take_field(st_reg, ESC_BYTE, max_length);
                f1.st.pend = 1'b0;
                f2      = take_field(f1.st, in_byte_reg, max_length);
                push.v0 = f1.rv;
                push.r0 = f1.res;
                st_next = f1.st;
                if (in_byte_reg != ESC_NULL && f1.st.phase != PH_HUNT)
                begin
                    push.v1 = f2.rv;
                    push.r1 = f2.res;
                    st_next = f2.st;
                    // Keep results contiguous when only the second produced one
                    if (!f1.rv)
                    begin
                        push.v0 = f2.rv;
                        push.r0 = f2.res;
                        push.v1 = 1'b0;
                    end
                end
                st_next.idle = 16'd0;
            end
            else if (in_byte_reg == ESC_BYTE)
                st_next.pend = 1'b1;
            else
            begin
                push.v0      = f1.rv;
                push.r0      = f1.res;
                st_next      = f1.st;
                st_next.idle = 16'd0;
            end
        end
        if (!adv)
            push = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_op_reg   <= in_op;
            in_byte_reg <= in_byte;
        end
    end

    // The all-zero state is hunting with every held field cleared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (adv)
            st_reg <= st_next;
    end

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0)
        else $error("second result pushed without a first");

    a_status_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ((push.v0 && push.r0.kind) || (push.v1 && push.r1.kind)) |=>
        (st_reg.phase == PH_HUNT))
        else $error("status beat did not return the deframer to hunting");

    a_escape_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.pend |-> (st_reg.phase != PH_HUNT && st_reg.phase != PH_TYPE))
        else $error("escape pending outside a frame");

endmodule

/* rtl/sfr_oq.sv */
// ----------------------------------------------------------------------------
// sfr_oq
// Small output queue: up to two results in, one out a cycle while out_ready.
// ----------------------------------------------------------------------------
module sfr_oq
    import sfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    result_t             mem_reg [OQ_DEPTH];
    logic [OQ_IDX_W-1:0] wr_ptr_reg;
    logic [OQ_IDX_W-1:0] rd_ptr_reg;
    logic [OQ_CNT_W-1:0] cnt_reg;
    logic [OQ_IDX_W-1:0] wr_ptr_inc;
    logic [OQ_IDX_W-1:0] wr_ptr_inc2;
    logic [OQ_IDX_W-1:0] rd_ptr_inc;
    logic [OQ_IDX_W-1:0] wr_ptr_next;
    logic                pop;

    function automatic logic [OQ_IDX_W-1:0] ptr_inc(logic [OQ_IDX_W-1:0] p);
        return (p == OQ_IDX_W'(OQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_inc  = ptr_inc(wr_ptr_reg);
    assign wr_ptr_inc2 = ptr_inc(wr_ptr_inc);
    assign rd_ptr_inc  = ptr_inc(rd_ptr_reg);
    assign wr_ptr_next = push.v1 ? wr_ptr_inc2 : (push.v0 ? wr_ptr_inc : wr_ptr_reg);

    assign out_valid = (cnt_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= OQ_CNT_W'(OQ_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.v0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.v1)
            mem_reg[wr_ptr_inc] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_inc;
            cnt_reg <= cnt_reg + OQ_CNT_W'(push.v0) + OQ_CNT_W'(push.v1)
                       - OQ_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue overflow");

    a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> room)
        else $error("result pushed without two free entries");

endmodule

/* rtl/stuffed_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_top
// Byte-stuffed frame deframer with additive checksum and APB configuration.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_axis    in         tuser = op (0 byte, 1 tick); tdata[7:0] = rx_byte
//  m_axis    out        tuser = kind; tlast = last; tdata = data, status,
//                       frame_id, frame_seq, frame_length
//  apb       in/out     reg 0 max_length at 0x0, reg 1 timeout_ticks at 0x4
//
// An input beat is held in the input register, its first result is written into
// the output queue and is valid on m_axis from there; one beat per cycle is kept
// up while m_axis is ready and beats yield one result on average. A step needs
// two free entries in the four-entry output queue, so back-pressure fills the
// queue, holds the input register, then drops tready. Reset clears the deframer
// to hunting, empties the queue and loads the registers with 65535 and 1000.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_top
    import sfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    input  logic              s_axis_tuser,   // [0] op
    // Result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // [7:0] data, [10:8] status,
                                              // [18:11] frame_id, [26:19] frame_seq,
                                              // [42:27] frame_length, rest zero
    output logic              m_axis_tuser,   // [0] kind
    output logic              m_axis_tlast,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] max_length;
    logic [15:0] timeout_ticks;
    logic        room;
    push_t       push;
    result_t     out_res;

    sfr_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .max_length    (max_length),
        .timeout_ticks (timeout_ticks)
    );

    // Deframer: input register, state and the per-beat decision logic.
    sfr_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_op         (s_axis_tuser),
        .in_byte       (s_axis_tdata),
        .max_length    (max_length),
        .timeout_ticks (timeout_ticks),
        .room          (room),
        .push          (push)
    );

    // Results wait here so that the input side keeps moving under stalls.
    sfr_oq u_oq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {5'd0, out_res.frame_length, out_res.frame_seq,
                           out_res.frame_id, out_res.status, out_res.data};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.kind;

endmodule
